>>> hw/rtl/ils_pkg.sv
// Shared opcodes, status codes and the cell command type for the indexed list store.
package ils_pkg;

    // Widths fixed by the item fields and by the largest supported depth
    localparam int OP_W   = 4;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 11;
    localparam int FIDX_W = 6;
    localparam int ST_W   = 3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH   = 4'd0;
    localparam logic [OP_W-1:0] OP_POP    = 4'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 4'd2;
    localparam logic [OP_W-1:0] OP_ERASE  = 4'd3;
    localparam logic [OP_W-1:0] OP_FIND   = 4'd4;
    localparam logic [OP_W-1:0] OP_READ   = 4'd5;
    localparam logic [OP_W-1:0] OP_WRITE  = 4'd6;
    localparam logic [OP_W-1:0] OP_CLEAR  = 4'd7;
    localparam logic [OP_W-1:0] OP_RESIZE = 4'd8;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic              upd;    // operation passed its checks, cells may change
        logic [OP_W-1:0]   op;
        logic [CNT_W-1:0]  pos;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

>>> hw/rtl/indexed_list_store_top.sv
// Top level of the indexed list store: count, result logic and the chain of element cells.
// The result beat is registered and presented in the cycle after the input beat is accepted.
// One operation per cycle while results drain; every slot shifts or compares in parallel.
// The input is taken whenever the result register is empty or being drained.
// Reset clears the element count and the result valid; slot contents are not cleared.
module indexed_list_store_top
    import ils_pkg::*;
#(
    parameter int LIST_DEPTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_opcode,
    input  logic [POS_W-1:0]  s_position,
    input  logic [DATA_W-1:0] s_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_read_value,
    output logic [FIDX_W-1:0] m_found_index,
    output logic [POS_W-1:0]  m_element_total,
    output logic [ST_W-1:0]   m_status
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int IW = $clog2(LIST_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              m_valid_reg;
    logic [DATA_W-1:0] rd_reg;
    logic [FIDX_W-1:0] fidx_reg;
    logic [POS_W-1:0]  total_reg;
    logic [ST_W-1:0]   st_reg;

    logic              s_fire;
    logic [CNT_W-1:0]  cnt_w;
    logic [CNT_W-1:0]  pos_w;
    logic [CNT_W-1:0]  cnt_next_w;
    logic [CNT_W-1:0]  fidx_w;
    cell_cmd_t         cmd;
    logic              upd;
    logic [ST_W-1:0]   st;
    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] rd_any;
    logic              any_match;
    logic [IW-1:0]     first_idx;

    logic [DATA_W-1:0] cell_data [LIST_DEPTH];
    logic [DATA_W-1:0] cell_tap  [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] cell_match;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign cnt_w   = CNT_W'(count_reg);
    assign pos_w   = CNT_W'(s_position);

    // Operation checks, new count and status
    always_comb begin
        upd        = 1'b0;
        st         = ST_OK;
        rd         = '0;
        count_next = count_reg;
        case (s_opcode)
            OP_PUSH: begin
                if (cnt_w >= DEPTH_C) begin
                    st = ST_FULL;
                end else begin
                    upd        = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_POP: begin
                if (cnt_w == '0) begin
                    st = ST_EMPTY;
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end
            OP_INSERT: begin
                if (pos_w > cnt_w) begin
                    st = ST_BADPOS;
                end else if (cnt_w >= DEPTH_C) begin
                    st = ST_FULL;
                end else begin
                    upd        = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_ERASE: begin
                if (pos_w >= cnt_w) begin
                    st = ST_BADPOS;
                end else begin
                    upd        = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_FIND: begin
                st = any_match ? ST_OK : ST_NOTFOUND;
            end
            OP_READ: begin
                if (pos_w >= cnt_w) begin
                    st = ST_BADPOS;
                end else begin
                    rd = rd_any;
                end
            end
            OP_WRITE: begin
                if (pos_w >= cnt_w) begin
                    st = ST_BADPOS;
                end else begin
                    upd = 1'b1;
                end
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            OP_RESIZE: begin
                if (pos_w > DEPTH_C) begin
                    st = ST_FULL;
                end else begin
                    upd        = 1'b1;
                    count_next = CW'(pos_w);
                end
            end
            default: begin
                st = ST_OK;
            end
        endcase
    end

    // Broadcast command; cells only change on an accepted beat
    always_comb begin
        cmd       = '0;
        cmd.upd   = upd && s_fire;
        cmd.op    = s_opcode;
        cmd.pos   = pos_w;
        cmd.count = cnt_w;
        cmd.value = s_value;
    end

    // Chain of element cells
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;
        if (g == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid
            assign left_d = cell_data[g-1];
        end
        if (g == LIST_DEPTH - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_inner
            assign right_d = cell_data[g+1];
        end
        ils_cell #(
            .IDX(g)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .left_data (left_d),
            .right_data(right_d),
            .data      (cell_data[g]),
            .match     (cell_match[g]),
            .rd_tap    (cell_tap[g])
        );
    end

    // Read tap merge and first-match encode
    always_comb begin
        rd_any    = '0;
        first_idx = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            rd_any = rd_any | cell_tap[i];
        end
        for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
            if (cell_match[i]) first_idx = IW'(i);
        end
    end

    assign any_match  = |cell_match;
    assign cnt_next_w = CNT_W'(count_next);
    assign fidx_w     = (s_opcode == OP_FIND && any_match) ? CNT_W'(first_idx) : '0;

    // Count and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rd_reg    <= rd;
            fidx_reg  <= fidx_w[FIDX_W-1:0];
            total_reg <= cnt_next_w[POS_W-1:0];
            st_reg    <= st;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_read_value    = rd_reg;
    assign m_found_index   = fidx_reg;
    assign m_element_total = total_reg;
    assign m_status        = st_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'(count_reg) <= DEPTH_C)
        else $error("element count above depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_opcode == OP_PUSH && CNT_W'(count_reg) < DEPTH_C
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not grow the count");

    a_fire_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid_reg)
        else $error("accepted beat left no result");

    a_notfound_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && st_reg == ST_NOTFOUND |-> fidx_reg == '0)
        else $error("miss carries a nonzero index");
`endif

endmodule

>>> hw/rtl/ils_cell.sv
// One element slot of the list: holds a value and trades it with its neighbors.
module ils_cell
    import ils_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic              aclk,
    input  cell_cmd_t         cmd,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data,
    output logic              match,
    output logic [DATA_W-1:0] rd_tap
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] MY_NXT = CNT_W'(IDX + 1);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // Next slot value for the broadcast operation
    always_comb begin
        data_next = data_reg;
        if (cmd.upd) begin
            case (cmd.op)
                OP_PUSH: begin
                    if (MY_IDX == cmd.count) data_next = cmd.value;
                end
                OP_INSERT: begin
                    if (MY_IDX == cmd.pos) begin
                        data_next = cmd.value;
                    end else if (MY_IDX > cmd.pos && MY_IDX <= cmd.count) begin
                        data_next = left_data;
                    end
                end
                OP_ERASE: begin
                    if (MY_IDX >= cmd.pos && MY_NXT < cmd.count) data_next = right_data;
                end
                OP_WRITE: begin
                    if (MY_IDX == cmd.pos) data_next = cmd.value;
                end
                OP_RESIZE: begin
                    if (MY_IDX >= cmd.count && MY_IDX < cmd.pos) data_next = cmd.value;
                end
                default: begin
                    data_next = data_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    // Key compare limited to live slots; read tap selects the slot at the command position
    assign data   = data_reg;
    assign match  = (data_reg == cmd.value) && (MY_IDX < cmd.count);
    assign rd_tap = (MY_IDX == cmd.pos) ? data_reg : '0;

endmodule
